// ----- rtl/core/kmh_pkg.sv -----
// ----------------------------------------------------------------------------
// kmh_pkg: shared types and constants for the k-ary max-heap builder
// Holds the element width and the result beat structure that passes from
// the sequencer to the output register.
// ----------------------------------------------------------------------------
package kmh_pkg;

    // Width of one stored element.
    localparam int DATA_W = 32;

    // One result beat as handed from the sequencer to the output stage.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              overflow;
    } out_beat_t;

endpackage

// ----- rtl/core/kary_max_heap_build_core.sv -----
// ----------------------------------------------------------------------------
// kary_max_heap_build_core: k-ary max-heap builder
// Collects signed elements until a beat marked last, arranges them into a
// max-heap with ARITY children per node and streams the heap out root first.
//
//   Channel  Dir  tdata (low bit up)   tlast        tuser
//   s_       in   [31:0] value         is_last      -
//   m_       out  [31:0] value_res     is_last_res  [0] overflow
//
// Loading takes one input beat per cycle. Building fetches each sift's parent
// in ST_NODE_RD and ST_NODE_CAP and each child examined in ST_CHILD_RD and
// ST_CHILD_CMP, ends the child scan in ST_CHILD_RD at a missing child and
// writes each level of a sift in ST_DECIDE, all set by the single registered
// RAM read port. Emission reads each result beat in ST_EMIT_RD and offers it
// in ST_EMIT_CAP. No input is taken while a set is being built or emitted.
// The element RAM needs no clearing after reset; reset returns the count and
// overflow flag to zero. A stalled m_ side holds the sequencer in emission.
// ----------------------------------------------------------------------------
module kary_max_heap_build_core #(
    parameter int ARITY = 3,
    parameter int DEPTH = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [kmh_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                       s_tlast,   // is_last
    // Result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [kmh_pkg::DATA_W-1:0] m_tdata,   // [31:0] value_res
    output logic                       m_tlast,   // is_last_res
    output logic                       m_tuser    // [0] overflow
);

    localparam int AW = $clog2(DEPTH);

    logic                       emit_valid;
    logic                       emit_ready;
    kmh_pkg::out_beat_t         emit_beat;
    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [kmh_pkg::DATA_W-1:0] mem_wr_data;
    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    logic [kmh_pkg::DATA_W-1:0] mem_rd_data;

    logic                       m_valid_reg;
    kmh_pkg::out_beat_t         m_beat_reg;

    // Sequencer.
    kmh_seq #(
        .ARITY (ARITY),
        .DEPTH (DEPTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_value    (s_tdata),
        .in_last     (s_tlast),
        .emit_valid  (emit_valid),
        .emit_ready  (emit_ready),
        .emit_beat   (emit_beat),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Element store.
    kmh_ram #(
        .WIDTH (kmh_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: takes a new beat when empty or being drained.
    assign emit_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_valid && emit_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid && emit_ready) begin
            m_beat_reg <= emit_beat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_beat_reg.value;
    assign m_tlast  = m_beat_reg.last;
    assign m_tuser  = m_beat_reg.overflow;

endmodule

// ----- rtl/core/kmh_ram.sv -----
// ----------------------------------------------------------------------------
// kmh_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered and holds
// its value until the next read is enabled.
// ----------------------------------------------------------------------------
module kmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/kmh_seq.sv -----
// ----------------------------------------------------------------------------
// kmh_seq: load, heap-build and emission sequencer
// Stores incoming elements, sifts down from the last parent to the root with
// read-modify-write accesses to the element RAM, then reads the heap out in
// order and hands each result beat to the output stage.
// ----------------------------------------------------------------------------
module kmh_seq #(
    parameter int ARITY = 3,
    parameter int DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input beats
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kmh_pkg::DATA_W-1:0]    in_value,
    input  logic                          in_last,
    // Result beats
    output logic                          emit_valid,
    input  logic                          emit_ready,
    output kmh_pkg::out_beat_t            emit_beat,
    // Element RAM
    output logic                          mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
    output logic [kmh_pkg::DATA_W-1:0]    mem_wr_data,
    output logic                          mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]      mem_rd_addr,
    input  logic [kmh_pkg::DATA_W-1:0]    mem_rd_data
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CHW = $clog2(DEPTH * ARITY + 1);
    localparam int SW  = $clog2(ARITY);
    localparam int KW  = $clog2(ARITY + 1);

    localparam logic [CW-1:0]  DEPTH_C  = CW'(DEPTH);
    localparam logic [CHW-1:0] ARITY_CH = CHW'(ARITY);
    localparam logic [SW-1:0]  SUB_MAX  = SW'(ARITY - 1);
    localparam logic [KW-1:0]  KID_MAX  = KW'(ARITY);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_NODE_RD,
        ST_NODE_CAP,
        ST_CHILD_RD,
        ST_CHILD_CMP,
        ST_DECIDE,
        ST_EMIT_RD,
        ST_EMIT_CAP
    } state_t;

    state_t                     state_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       ovf_reg;
    logic [AW-1:0]              par_reg;
    logic [SW-1:0]              sub_reg;
    logic [AW-1:0]              lastp_reg;
    logic [AW-1:0]              p_reg;
    logic [AW-1:0]              node_reg;
    logic [AW-1:0]              best_reg;
    logic [CHW-1:0]             ch_reg;
    logic [KW-1:0]              kid_reg;
    logic [AW-1:0]              k_reg;
    logic [kmh_pkg::DATA_W-1:0] node_val_reg;
    logic [kmh_pkg::DATA_W-1:0] best_val_reg;

    logic          store_ok;
    logic [CW-1:0] cnt_next;
    logic          child_ok;
    logic          child_gt;
    logic          emit_is_last;

    // Load-phase decode.
    assign store_ok = (cnt_reg < DEPTH_C);
    assign cnt_next = store_ok ? (cnt_reg + CW'(1)) : cnt_reg;
    assign in_ready = (state_reg == ST_LOAD);

    // Child range test and signed comparison against the current best.
    assign child_ok = (ch_reg < CHW'(cnt_reg));
    assign child_gt = ($signed(mem_rd_data) > $signed(best_val_reg));

    // Emission.
    assign emit_is_last    = ((CW'(k_reg) + CW'(1)) == cnt_reg);
    assign emit_valid      = (state_reg == ST_EMIT_CAP);
    assign emit_beat.value = mem_rd_data;
    assign emit_beat.last  = emit_is_last;
    assign emit_beat.overflow = ovf_reg;

    // RAM port control.
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = cnt_reg[AW-1:0];
        mem_wr_data = in_value;
        mem_rd_en   = 1'b0;
        mem_rd_addr = node_reg;
        case (state_reg)
            ST_LOAD: begin
                mem_wr_en = in_valid && store_ok;
            end
            ST_NODE_RD: begin
                mem_rd_en = 1'b1;
            end
            ST_CHILD_RD: begin
                mem_rd_en   = child_ok;
                mem_rd_addr = ch_reg[AW-1:0];
            end
            ST_DECIDE: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = node_reg;
                mem_wr_data = (best_reg != node_reg) ? best_val_reg : node_val_reg;
            end
            ST_EMIT_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = k_reg;
            end
            default: begin
            end
        endcase
    end

    // Sequencer state and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            par_reg   <= '0;
            sub_reg   <= '0;
            lastp_reg <= '0;
            p_reg     <= '0;
            node_reg  <= '0;
            best_reg  <= '0;
            ch_reg    <= '0;
            kid_reg   <= '0;
            k_reg     <= '0;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (in_valid) begin
                        cnt_reg <= cnt_next;
                        if (!store_ok) begin
                            ovf_reg <= 1'b1;
                        end
                        // Track the parent of each stored element so that the
                        // last parent is known when the set closes.
                        if (store_ok && (cnt_reg != '0)) begin
                            lastp_reg <= par_reg;
                            if (sub_reg == SUB_MAX) begin
                                sub_reg <= '0;
                                par_reg <= par_reg + AW'(1);
                            end else begin
                                sub_reg <= sub_reg + SW'(1);
                            end
                        end
                        if (in_last) begin
                            k_reg <= '0;
                            if (cnt_next < CW'(2)) begin
                                state_reg <= ST_EMIT_RD;
                            end else if (store_ok && (cnt_reg != '0)) begin
                                p_reg     <= par_reg;
                                node_reg  <= par_reg;
                                state_reg <= ST_NODE_RD;
                            end else begin
                                p_reg     <= lastp_reg;
                                node_reg  <= lastp_reg;
                                state_reg <= ST_NODE_RD;
                            end
                        end
                    end
                end
                ST_NODE_RD: begin
                    state_reg <= ST_NODE_CAP;
                end
                ST_NODE_CAP: begin
                    node_val_reg <= mem_rd_data;
                    best_val_reg <= mem_rd_data;
                    best_reg     <= node_reg;
                    ch_reg       <= CHW'(CHW'(node_reg) * ARITY_CH + CHW'(1));
                    kid_reg      <= KW'(1);
                    state_reg    <= ST_CHILD_RD;
                end
                ST_CHILD_RD: begin
                    // Children are contiguous: the first missing one ends the scan.
                    state_reg <= child_ok ? ST_CHILD_CMP : ST_DECIDE;
                end
                ST_CHILD_CMP: begin
                    if (child_gt) begin
                        best_val_reg <= mem_rd_data;
                        best_reg     <= ch_reg[AW-1:0];
                    end
                    if (kid_reg == KID_MAX) begin
                        state_reg <= ST_DECIDE;
                    end else begin
                        kid_reg   <= kid_reg + KW'(1);
                        ch_reg    <= ch_reg + CHW'(1);
                        state_reg <= ST_CHILD_RD;
                    end
                end
                ST_DECIDE: begin
                    if (best_reg != node_reg) begin
                        // The greater child moved up; carry the sifted value on
                        // down from the child's slot.
                        node_reg     <= best_reg;
                        best_val_reg <= node_val_reg;
                        ch_reg       <= CHW'(CHW'(best_reg) * ARITY_CH + CHW'(1));
                        kid_reg      <= KW'(1);
                        state_reg    <= ST_CHILD_RD;
                    end else if (p_reg == '0) begin
                        k_reg     <= '0;
                        state_reg <= ST_EMIT_RD;
                    end else begin
                        p_reg     <= p_reg - AW'(1);
                        node_reg  <= p_reg - AW'(1);
                        state_reg <= ST_NODE_RD;
                    end
                end
                ST_EMIT_RD: begin
                    state_reg <= ST_EMIT_CAP;
                end
                ST_EMIT_CAP: begin
                    if (emit_ready) begin
                        if (emit_is_last) begin
                            cnt_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            par_reg   <= '0;
                            sub_reg   <= '0;
                            lastp_reg <= '0;
                            state_reg <= ST_LOAD;
                        end else begin
                            k_reg     <= k_reg + AW'(1);
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule
